FILE: rtl/irdal_pkg.sv
`default_nettype none
package irdal_pkg;

   // fixed field widths
   localparam int CNT_W  = 8;
   localparam int DEN_W  = 12;
   localparam int DIST_W = 7;
   localparam int AVG_W  = 10;
   localparam int LIN_W  = 16;
   localparam int OFF_W  = 9;
   localparam int BP_N   = 8;

   localparam logic [CNT_W-1:0]  COUNT_RESET = 8'd100;
   localparam logic [LIN_W-1:0]  LOW_LIMIT   = 16'd80;
   localparam logic [LIN_W-1:0]  HOLD_LIMIT  = 16'd490;
   localparam logic [DIST_W-1:0] NEAR_DIST   = 7'd80;
   localparam int                HALF_SEG    = 2;

   // breakpoints, lowest first (index 0 in the low bits)
   localparam logic [BP_N-1:0][OFF_W-1:0] BP_TABLE =
      {9'd490, 9'd276, 9'd196, 9'd150, 9'd124, 9'd106, 9'd87, 9'd80};
   localparam logic [BP_N-1:0][DIST_W-1:0] BASE_TABLE =
      {7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80};
   // segment slopes in hundredths of a count per cm; half segment unused
   localparam logic [BP_N-2:0][DEN_W-1:0] HUND_TABLE =
      {12'd2377, 12'd888, 12'd511, 12'd288, 12'd0, 12'd211, 12'd77};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_AVG,
      ST_LIN,
      ST_DIV_SEG,
      ST_WRITE
   } state_type;

   typedef enum logic [1:0] {
      SEG_FIXED,
      SEG_HALF,
      SEG_DIV,
      SEG_HOLD
   } seg_kind_type;

   typedef struct packed {
      seg_kind_type      kind;
      logic [DIST_W-1:0] base;
      logic [OFF_W-1:0]  start;
      logic [DEN_W-1:0]  hund;
   } seg_type;

   // classify an average against the breakpoint table
   function automatic seg_type seg_lookup(logic [LIN_W-1:0] avg);
      seg_type s;
      s.kind  = SEG_FIXED;
      s.base  = NEAR_DIST;
      s.start = '0;
      s.hund  = '0;
      if (avg > HOLD_LIMIT) begin
         s.kind = SEG_HOLD;
      end else if (avg > LOW_LIMIT) begin
         for (int i = 0; i < BP_N; i++) begin
            if (avg == LIN_W'(BP_TABLE[i])) begin
               s.kind = SEG_FIXED;
               s.base = BASE_TABLE[i];
            end
         end
         for (int i = 0; i < BP_N - 1; i++) begin
            if (avg > LIN_W'(BP_TABLE[i]) && avg < LIN_W'(BP_TABLE[i+1])) begin
               s.kind  = (i == HALF_SEG) ? SEG_HALF : SEG_DIV;
               s.base  = BASE_TABLE[i];
               s.start = BP_TABLE[i];
               s.hund  = HUND_TABLE[i];
            end
         end
      end
      return s;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/irdal_divider.sv
`default_nettype none
module irdal_divider
   import irdal_pkg::*;
#(
   parameter int NUM_W = 18
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  done,
   output logic [NUM_W-1:0]      quotient
);

   localparam int CW = $clog2(NUM_W + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   shifted;
   logic             fits;

   // one restoring step per cycle, quotient bits shift in behind the dividend
   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      fits    = shifted >= {1'b0, den_ff};
      run_in  = run_ff && (cnt_ff != CW'(1));
      done_in = run_ff && (cnt_ff == CW'(1));
      cnt_in  = run_ff ? cnt_ff - CW'(1) : cnt_ff;
      quo_in  = run_ff ? {quo_ff[NUM_W-2:0], fits} : quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (run_ff) begin
         rem_in = fits ? DEN_W'(shifted - {1'b0, den_ff}) : shifted[DEN_W-1:0];
      end
      if (start) begin
         run_in = 1'b1;
         cnt_in = CW'(NUM_W);
         quo_in = numer;
         rem_in = '0;
         den_in = denom;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

FILE: rtl/ir_distance_average_linearize.sv
// A word that does not end a batch is absorbed as it is taken.
// A batch-ending word starts a serial divider pass for the average and, on a sloped segment,
// a second pass for the slope before the result is written; no segment division is needed
// on the fixed, half and hold segments.
// Throughput: one word at a time; req_tready is low while a batch resolves.
// Reset (synchronous, active high): count 100, sum, taken count and last distance clear.
`default_nettype none
module ir_distance_average_linearize
   import irdal_pkg::*;
#(
   parameter int SAMPLE_BITS = 10
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // csr_data: sample_count[7:0]
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [CNT_W-1:0]                     csr_data,
   // req_tdata: adc_sample[SAMPLE_BITS-1:0], zero padded
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   // rsp_tdata: distance_cm[6:0], average[16:7], zero padded to 24
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [23:0]                               rsp_tdata,
   // rsp_tuser: held[0]
   output logic                                      rsp_tuser
);

   localparam int SUM_W = SAMPLE_BITS + 8;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]       taken_ff, taken_in;
   logic [DIST_W-1:0]      last_ff, last_in;
   logic [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic [DIST_W-1:0]      dist_ff, dist_in;
   logic                   held_ff, held_in;
   logic [DIST_W-1:0]      base_ff, base_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]      rsp_dist_ff, rsp_dist_in;
   logic [AVG_W-1:0]       rsp_avg_ff, rsp_avg_in;
   logic                   rsp_held_ff, rsp_held_in;

   logic [SAMPLE_BITS-1:0] sample;
   logic [CNT_W-1:0]       count_eff;
   logic [SUM_W-1:0]       sum_next;
   logic [CNT_W-1:0]       taken_next;
   logic                   batch_end;
   logic                   req_fire;
   logic                   slot_free;
   seg_type                seg;
   logic [OFF_W-1:0]       seg_off;
   logic [LIN_W-1:0]       seg_numer;
   logic [DIST_W-1:0]      half_dist;
   logic [SAMPLE_BITS-1:0] avg_sat;
   logic [DIST_W-1:0]      slope_dist;

   logic                   div_start;
   logic [SUM_W-1:0]       div_numer;
   logic [DEN_W-1:0]       div_denom;
   logic                   div_done;
   logic [SUM_W-1:0]       div_quot;

   irdal_divider #(
      .NUM_W (SUM_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (div_denom),
      .done     (div_done),
      .quotient (div_quot)
   );

   // accumulate and linearize datapath
   always_comb begin
      sample     = req_tdata[SAMPLE_BITS-1:0];
      count_eff  = (count_ff == '0) ? CNT_W'(1) : count_ff;
      sum_next   = sum_ff + SUM_W'(sample);
      taken_next = taken_ff + CNT_W'(1);
      batch_end  = taken_next >= count_eff;
      req_fire   = req_tvalid && (state_ff == ST_IDLE);
      slot_free  = !rsp_valid_ff || rsp_tready;
      seg        = seg_lookup(LIN_W'(avg_ff));
      seg_off    = OFF_W'(LIN_W'(avg_ff) - LIN_W'(seg.start));
      seg_numer  = LIN_W'(LIN_W'(seg_off) * LIN_W'(100)) + LIN_W'(seg.hund) - LIN_W'(1);
      half_dist  = seg.base - DIST_W'(seg_off >> 1);
      avg_sat    = (div_quot > SUM_W'({SAMPLE_BITS{1'b1}})) ? '1
                                                           : div_quot[SAMPLE_BITS-1:0];
      slope_dist = (div_quot >= SUM_W'(base_ff)) ? '0 : base_ff - DIST_W'(div_quot);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_fire && batch_end) state_in = ST_DIV_AVG;
         ST_DIV_AVG: if (div_done) state_in = ST_LIN;
         ST_LIN:     state_in = (seg.kind == SEG_DIV) ? ST_DIV_SEG : ST_WRITE;
         ST_DIV_SEG: if (div_done) state_in = ST_WRITE;
         ST_WRITE:   if (slot_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake and divider operands
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      div_numer  = sum_next;
      div_denom  = DEN_W'(count_eff);
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            div_start  = req_fire && batch_end;
         end
         ST_LIN: begin
            div_start = seg.kind == SEG_DIV;
            div_numer = SUM_W'(seg_numer);
            div_denom = seg.hund;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // register next values
   always_comb begin
      count_in     = csr_valid ? csr_data : count_ff;
      sum_in       = sum_ff;
      taken_in     = taken_ff;
      last_in      = last_ff;
      avg_in       = avg_ff;
      dist_in      = dist_ff;
      held_in      = held_ff;
      base_in      = base_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_held_in  = rsp_held_ff;
      if (req_fire) begin
         sum_in   = batch_end ? '0 : sum_next;
         taken_in = batch_end ? '0 : taken_next;
      end
      if (state_ff == ST_DIV_AVG && div_done) begin
         avg_in = avg_sat;
      end
      if (state_ff == ST_LIN) begin
         held_in = 1'b0;
         base_in = seg.base;
         case (seg.kind)
            SEG_FIXED: dist_in = seg.base;
            SEG_HALF:  dist_in = half_dist;
            SEG_HOLD: begin
               dist_in = last_ff;
               held_in = 1'b1;
            end
            default:   dist_in = dist_ff;
         endcase
      end
      if (state_ff == ST_DIV_SEG && div_done) begin
         dist_in = slope_dist;
      end
      if (state_ff == ST_WRITE && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_dist_in  = dist_ff;
         rsp_avg_in   = AVG_W'(avg_ff);
         rsp_held_in  = held_ff;
         last_in      = dist_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= COUNT_RESET;
         sum_ff       <= '0;
         taken_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         taken_ff     <= taken_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      avg_ff      <= avg_in;
      dist_ff     <= dist_in;
      held_ff     <= held_in;
      base_ff     <= base_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_held_ff <= rsp_held_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_avg_ff, rsp_dist_ff};
   assign rsp_tuser  = rsp_held_ff;

   // divider completes only while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_AVG || state_ff == ST_DIV_SEG))
      else $error("divider done outside a wait state");

   // divider started only from idle or from the linearize state
   a_start_only_from_idle_or_lin: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (state_ff == ST_IDLE || state_ff == ST_LIN))
      else $error("divider started from wrong state");

   // a held result repeats the last delivered distance
   a_held_repeats_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_held_ff) |-> (rsp_dist_ff == last_ff))
      else $error("held distance differs from last distance");

   // held flag only for averages beyond the far breakpoint
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && held_ff) |-> (LIN_W'(avg_ff) > HOLD_LIMIT))
      else $error("held set for an in-range average");

endmodule
`default_nettype wire

FILE: sim/tb_ir_distance_average_linearize.sv
module tb_ir_distance_average_linearize;
   import irdal_pkg::*;

   localparam int SAMPLE_W        = 10;
   localparam int REQ_W           = ((SAMPLE_W + 7) / 8) * 8;
   localparam int SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
   localparam int HOLD_AVG        = 490;
   localparam int SETTLE_CYCLES   = 60;    // a little over the slowest batch end
   localparam int STALL_LIMIT     = 4000;  // cycles with no word moving on any channel
   localparam int PRESSURE_CYCLES = 400;

   typedef struct packed {
      logic [DIST_W-1:0] distance_cm;
      logic [AVG_W-1:0]  average;
      logic              held;
   } distance_reading_t;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [CNT_W-1:0]    csr_data   = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [23:0]         rsp_tdata;
   logic                rsp_tuser;

   // mirror of the block's batch state
   logic [CNT_W-1:0]    count_setting = COUNT_RESET;
   logic [17:0]         batch_sum     = '0;
   logic [7:0]          batch_taken   = '0;
   logic [DIST_W-1:0]   last_cm       = '0;

   logic [SAMPLE_W-1:0] pending_samples[$];
   distance_reading_t   expected_readings[$];
   distance_reading_t   next_reading;
   distance_reading_t   want;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned stall_request = 0;
   int unsigned stall_left    = 0;
   int unsigned idle_cycles   = 0;
   int unsigned errors        = 0;
   int unsigned samples_sent  = 0;
   int unsigned readings_seen = 0;
   int unsigned held_seen     = 0;
   int unsigned settings_used = 0;
   bit          req_taken     = 1'b0;
   bit          csr_taken     = 1'b0;

   // every segment edge, both limits and the hold threshold
   int unsigned directed_samples[25] = '{
      1023, 0, 80, 81, 86, 87, 88, 105, 106, 107, 123, 124, 125,
      149, 150, 151, 195, 196, 197, 275, 276, 277, 489, 490, 491};

   ir_distance_average_linearize #(
      .SAMPLE_BITS(SAMPLE_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // base - ceil(offset / (hund / 100)), floored at zero
   function automatic int unsigned cm_on_slope(input int unsigned base, input int unsigned off,
                                               input int unsigned hund);
      int unsigned steps;
      steps = (off * 100 + hund - 1) / hund;
      return (steps >= base) ? 0 : base - steps;
   endfunction

   function automatic int unsigned cm_from_average(input int unsigned avg);
      if (avg <= 80)  return 80;
      if (avg < 87)   return cm_on_slope(80, avg - 80, 77);
      if (avg == 87)  return 70;
      if (avg < 106)  return cm_on_slope(70, avg - 87, 211);
      if (avg == 106) return 60;
      if (avg < 124)  return 60 - (avg - 106) / 2;
      if (avg == 124) return 50;
      if (avg < 150)  return cm_on_slope(50, avg - 124, 288);
      if (avg == 150) return 40;
      if (avg < 196)  return cm_on_slope(40, avg - 150, 511);
      if (avg == 196) return 30;
      if (avg < 276)  return cm_on_slope(30, avg - 196, 888);
      if (avg == 276) return 20;
      if (avg < 490)  return cm_on_slope(20, avg - 276, 2377);
      return 10;
   endfunction

   // add one sample to the running batch; returns 1 when the batch closes
   function automatic bit absorb_sample(input logic [SAMPLE_W-1:0] sample,
                                        output distance_reading_t reading);
      int unsigned divisor;
      int unsigned mean;
      divisor     = (count_setting == 0) ? 1 : count_setting;
      batch_sum   = batch_sum + sample;
      batch_taken = batch_taken + 8'd1;
      reading     = '0;
      if (batch_taken < divisor) return 1'b0;
      mean = batch_sum / divisor;
      if (mean > SAMPLE_MAX) mean = SAMPLE_MAX;
      batch_sum   = '0;
      batch_taken = '0;
      reading.held = (mean > HOLD_AVG);
      if (!reading.held) last_cm = DIST_W'(cm_from_average(mean));
      reading.distance_cm = last_cm;
      reading.average     = AVG_W'(mean);
      return 1'b1;
   endfunction

   // sample driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata  <= REQ_W'(pending_samples.pop_front());
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      req_taken = 1'b0;
   end

   // result receiver, with an optional long hold-off
   always @(negedge clock) begin
      if (stall_request != 0) begin
         stall_left    = stall_request;
         stall_request = 0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: track config, predict on each accepted sample, check each reading
   always @(posedge clock) begin
      if (reset) begin
         count_setting = COUNT_RESET;
         batch_sum     = '0;
         batch_taken   = '0;
         last_cm       = '0;
         idle_cycles   = 0;
      end else begin
         idle_cycles++;
         if (csr_valid && csr_ready) begin
            count_setting = csr_data;
            csr_taken     = 1'b1;
            idle_cycles   = 0;
         end
         if (req_tvalid && req_tready) begin
            req_taken   = 1'b1;
            idle_cycles = 0;
            samples_sent++;
            if (absorb_sample(req_tdata[SAMPLE_W-1:0], next_reading))
               expected_readings.push_back(next_reading);
         end
         if (rsp_tvalid && rsp_tready) begin
            idle_cycles = 0;
            readings_seen++;
            if (rsp_tuser) held_seen++;
            if (expected_readings.size() == 0) begin
               $error("reading with none pending: tdata %h tuser %b", rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_tdata[DIST_W-1:0] !== want.distance_cm) begin
                  $error("distance_cm: expected %0d, got %0d",
                         want.distance_cm, rsp_tdata[DIST_W-1:0]);
                  errors++;
               end
               if (rsp_tdata[DIST_W +: AVG_W] !== want.average) begin
                  $error("average: expected %0d, got %0d",
                         want.average, rsp_tdata[DIST_W +: AVG_W]);
                  errors++;
               end
               if (rsp_tuser !== want.held) begin
                  $error("held: expected %0d, got %0d", want.held, rsp_tuser);
                  errors++;
               end
            end
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("no word moved for %0d cycles", STALL_LIMIT);
            $display("ir_distance_average_linearize test failed");
            $finish;
         end
      end
   end

   task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // wait until every sample is in and every reading is out, then let the block settle
   task automatic settle();
      while (pending_samples.size() != 0 || req_tvalid || expected_readings.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input int unsigned value);
      @(negedge clock);
      csr_taken = 1'b0;
      csr_data  <= value[CNT_W-1:0];
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic int unsigned pick_count(input int mode, input int slot);
      int unsigned roll;
      roll = $urandom_range(99);
      if (slot == 0) return (mode == 2) ? 255 : mode + 1;
      if (roll < 50) return $urandom_range(1, 4);
      if (roll < 85) return $urandom_range(5, 20);
      return $urandom_range(21, 255);
   endfunction

   // whole batches around a chosen level; some land on breakpoints, some are pure noise
   task automatic queue_batches(input int unsigned per_batch, input int unsigned min_items);
      int unsigned queued;
      int unsigned roll;
      int          level;
      int          spread;
      int          value;
      bit          noisy;
      queued = 0;
      while (queued < min_items) begin
         roll  = $urandom_range(99);
         noisy = 1'b0;
         if (roll < 25) begin
            level  = int'(BP_TABLE[$urandom_range(BP_N - 1)]) + int'($urandom_range(2)) - 1;
            spread = 0;
         end else if (roll < 85) begin
            level  = $urandom_range(40, 530);
            spread = $urandom_range(6);
         end else begin
            level  = 0;
            spread = 0;
            noisy  = 1'b1;
         end
         for (int i = 0; i < per_batch; i++) begin
            if (noisy) begin
               value = $urandom_range(SAMPLE_MAX);
            end else begin
               value = level + int'($urandom_range(2 * spread)) - spread;
               if (value < 0) value = 0;
               else if (value > SAMPLE_MAX) value = SAMPLE_MAX;
            end
            pending_samples.push_back(SAMPLE_W'(value));
         end
         queued += per_batch;
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      set_idling(15, 50);

      // reset count of 100; first reading is held while no distance exists yet
      for (int i = 0; i < 100; i++) pending_samples.push_back(SAMPLE_W'($urandom_range(491, 1023)));
      settle();

      // count of zero closes a batch on every sample: walk the segment edges
      write_count(0);
      foreach (directed_samples[i]) pending_samples.push_back(SAMPLE_W'(directed_samples[i]));
      settle();

      // full-scale sum, then the count dropped so the quotient saturates
      write_count(255);
      for (int i = 0; i < 200; i++) pending_samples.push_back(SAMPLE_W'(SAMPLE_MAX));
      settle();
      write_count(1);
      pending_samples.push_back(SAMPLE_W'(SAMPLE_MAX));
      settle();

      // count lowered below the samples already taken in an open batch
      write_count(8);
      for (int i = 0; i < 6; i++) pending_samples.push_back(SAMPLE_W'($urandom_range(60, 300)));
      settle();
      write_count(3);
      pending_samples.push_back(SAMPLE_W'($urandom_range(60, 300)));
      settle();

      // back pressure: receiver holds off while samples keep coming
      set_idling(0, 0);
      write_count(1);
      @(posedge clock);
      stall_request = PRESSURE_CYCLES;
      for (int i = 0; i < 40; i++) pending_samples.push_back(SAMPLE_W'($urandom_range(SAMPLE_MAX)));
      settle();

      // random batches under three idling patterns
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: set_idling(15, 50);
            1: set_idling(50, 15);
            default: set_idling(0, 0);
         endcase
         for (int slot = 0; slot < 5; slot++) begin
            automatic int unsigned per_batch = pick_count(mode, slot);
            write_count(per_batch);
            queue_batches(per_batch, 75);
            settle();
         end
      end

      $display("Covered %0d samples giving %0d distance readings (%0d held) over %0d count settings,",
               samples_sent, readings_seen, held_seen, settings_used);
      $display("including count zero and 255, mid-batch count drops, saturation and a %0d-cycle stall.",
               PRESSURE_CYCLES);
      if (errors == 0) begin
         $display("ir_distance_average_linearize test passed");
      end else begin
         $display("ir_distance_average_linearize test failed");
      end
      $finish;
   end

endmodule
